// File: rtl/core/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// shared types and constants for the character-cell line rasterizer
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int COORD_W       = 6;
    localparam int GLYPH_W       = 8;
    localparam int ADDR_W        = 12;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_IDX_W     = 1;
    localparam int MAX_COLS_DEF  = 64;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int COLS_RESET    = 64;
    localparam int ROWS_RESET    = 64;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;
    // signed step delta: -63..63
    localparam int DELTA_W       = COORD_W + 1;
    // error term: holds -2*63 .. 4*63
    localparam int ERR_W         = COORD_W + 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_COLS = 1'b0,
        REG_SCREEN_ROWS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [GLYPH_W-1:0] glyph;
    } t_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [ADDR_W-1:0]  cell_address;
        logic [GLYPH_W-1:0] glyph_out;
        logic               on_screen;
        logic               last;
    } t_result;

    // classified line job, handed from front to back through the queue
    typedef struct packed {
        logic                      steep;
        logic [COORD_W-1:0]        major_start;
        logic [COORD_W-1:0]        minor_start;
        logic [COORD_W-1:0]        span;
        logic signed [DELTA_W-1:0] delta;
        logic [GLYPH_W-1:0]        glyph;
    } t_job;

    // one stepped cell before address generation
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } t_pix;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// File: rtl/core/char_cell_line_rasterizer.sv
// ----------------------------------------------------------------------------
// char_cell_line_rasterizer
// rasterizes one line command into a run of character-cell writes
// ----------------------------------------------------------------------------
//
// channel    direction  handshake                    payload
// command    in         start & !busy                i_cmd (ccl_pkg::t_cmd)
// result     out        o_result_valid, one cycle    o_result (ccl_pkg::t_result)
// config     in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// the stepping unit loads each line from the job queue while idle, then writes
// one cell per cycle; that unit sets the rate
// results pass through the step register and then the address register
// commands are classified on accept and held in a two-entry queue; busy is
// high while the queue is full; zero-length lines never enter the queue
// reset (synchronous, active low) clears the queue, the stepper and the
// strobe, and loads both screen registers with 64 saturated to the maximum
// results cannot be stalled; config is always ready
//
module char_cell_line_rasterizer #(
    parameter int MAX_COLS = ccl_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = ccl_pkg::MAX_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command beat
    input  logic                              start,
    output logic                              busy,
    input  ccl_pkg::t_cmd                     i_cmd,
    // result beat
    output logic                              o_result_valid,
    output ccl_pkg::t_result                  o_result,
    // config beat
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ccl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // screen size registers hold up to the parameter maximum
    localparam int CW       = $clog2(MAX_COLS + 1);
    localparam int RW       = $clog2(MAX_ROWS + 1);
    localparam int AW       = (CW + RW + 1 > ccl_pkg::ADDR_W) ? CW + RW + 1 : ccl_pkg::ADDR_W;
    localparam int COLS_RST = (ccl_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : ccl_pkg::COLS_RESET;
    localparam int ROWS_RST = (ccl_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ccl_pkg::ROWS_RESET;

    logic [CW-1:0]          r_cols;
    logic [RW-1:0]          r_rows;

    logic                   take;
    logic                   push;
    ccl_pkg::t_job          front_job;
    ccl_pkg::t_job          queue_job;
    ccl_pkg::t_queue_stat   queue_stat;
    logic                   pop;
    logic                   pix_valid;
    ccl_pkg::t_pix          pix;

    logic                   on;
    logic [AW-1:0]          row_flip;
    logic [AW-1:0]          addr_full;

    assign take        = start && !busy;
    assign busy        = queue_stat.full;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration, saturated to the parameter maximum
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CW'(COLS_RST);
            r_rows <= RW'(ROWS_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (ccl_pkg::t_reg_idx'(i_cfg_index))
                ccl_pkg::REG_SCREEN_COLS: begin
                    r_cols <= (int'(i_cfg_data) > MAX_COLS) ? CW'(MAX_COLS) : CW'(i_cfg_data);
                end
                ccl_pkg::REG_SCREEN_ROWS: begin
                    r_rows <= (int'(i_cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(i_cfg_data);
                end
                default: begin
                    r_cols <= r_cols;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // front: classify, queue, back: step
    // ------------------------------------------------------------------
    ccl_front u_front (
        .i_cmd  (i_cmd),
        .i_take (take),
        .o_push (push),
        .o_job  (front_job)
    );

    ccl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_stat  (queue_stat)
    );

    ccl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (queue_job),
        .i_stat      (queue_stat),
        .o_pop       (pop),
        .o_pix_valid (pix_valid),
        .o_pix       (pix)
    );

    // ------------------------------------------------------------------
    // address stage: row flip, one multiply, registered result
    // ------------------------------------------------------------------
    always_comb begin
        on        = (AW'(pix.x) < AW'(r_cols)) && (AW'(pix.y) < AW'(r_rows));
        // only meaningful when on screen, where y < rows
        row_flip  = AW'(r_rows) - AW'(1) - AW'(pix.y);
        addr_full = row_flip * AW'(r_cols) + AW'(pix.x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.pixel_x      <= pix.x;
        o_result.pixel_y      <= pix.y;
        o_result.cell_address <= on ? addr_full[ccl_pkg::ADDR_W-1:0] : '0;
        o_result.glyph_out    <= pix.glyph;
        o_result.on_screen    <= on;
        o_result.last         <= pix.last;
    end

`ifndef ASSERT_OFF
    // the stepper goes idle after every line to reload from the queue, leaving a gap
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_valid && pix.last) |=> !pix_valid)
        else $error("cell step directly after the final cell of a line");

    // every stepped cell reaches the result port through the result register
    a_step_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_valid |=> o_result_valid)
        else $error("stepped cell lost before the result port");

    // queue status is never full and empty at once
    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(queue_stat.full && queue_stat.empty))
        else $error("queue reports full and empty together");

    // off-screen cells carry a zero address
    a_offscreen_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.on_screen) |-> (o_result.cell_address == '0))
        else $error("off-screen cell with nonzero address");
`endif

endmodule

// File: rtl/core/ccl_front.sv
// ----------------------------------------------------------------------------
// ccl_front
// classifies a line command into a stepping job (major axis, order, span)
// ----------------------------------------------------------------------------
module ccl_front (
    input  ccl_pkg::t_cmd  i_cmd,
    input  logic           i_take,
    output logic           o_push,
    output ccl_pkg::t_job  o_job
);

    logic [ccl_pkg::COORD_W-1:0] adx;
    logic [ccl_pkg::COORD_W-1:0] ady;
    logic                        steep;
    logic                        swap;

    always_comb begin
        adx   = (i_cmd.end_x > i_cmd.start_x) ? i_cmd.end_x - i_cmd.start_x
                                              : i_cmd.start_x - i_cmd.end_x;
        ady   = (i_cmd.end_y > i_cmd.start_y) ? i_cmd.end_y - i_cmd.start_y
                                              : i_cmd.start_y - i_cmd.end_y;
        steep = ady > adx;
        swap  = steep ? (i_cmd.end_y < i_cmd.start_y) : (i_cmd.end_x < i_cmd.start_x);

        o_job.steep = steep;
        o_job.glyph = i_cmd.glyph;
        o_job.span  = steep ? ady : adx;
        if (steep) begin
            o_job.major_start = swap ? i_cmd.end_y : i_cmd.start_y;
            o_job.minor_start = swap ? i_cmd.end_x : i_cmd.start_x;
            o_job.delta = swap
                ? $signed({1'b0, i_cmd.start_x}) - $signed({1'b0, i_cmd.end_x})
                : $signed({1'b0, i_cmd.end_x}) - $signed({1'b0, i_cmd.start_x});
        end else begin
            o_job.major_start = swap ? i_cmd.end_x : i_cmd.start_x;
            o_job.minor_start = swap ? i_cmd.end_y : i_cmd.start_y;
            o_job.delta = swap
                ? $signed({1'b0, i_cmd.start_y}) - $signed({1'b0, i_cmd.end_y})
                : $signed({1'b0, i_cmd.end_y}) - $signed({1'b0, i_cmd.start_y});
        end
        // zero-length lines produce no writes and never enter the queue
        o_push = i_take && (o_job.span != '0);
    end

endmodule

// File: rtl/core/ccl_fifo.sv
// ----------------------------------------------------------------------------
// ccl_fifo
// short job queue between the classifying front and the stepping back
// ----------------------------------------------------------------------------
module ccl_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ccl_pkg::t_job        i_job,
    input  logic                 i_pop,
    output ccl_pkg::t_job        o_job,
    output ccl_pkg::t_queue_stat o_stat
);

    ccl_pkg::t_job                     r_mem [ccl_pkg::QUEUE_DEPTH];
    logic [ccl_pkg::QUEUE_PTR_W-1:0]   r_wr_ptr;
    logic [ccl_pkg::QUEUE_PTR_W-1:0]   r_rd_ptr;
    logic [ccl_pkg::QUEUE_CNT_W-1:0]   r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_stat.full  = (r_count == ccl_pkg::QUEUE_CNT_W'(ccl_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/ccl_back.sv
// ----------------------------------------------------------------------------
// ccl_back
// steps one job along its major axis, one cell per cycle, error-term dda
// ----------------------------------------------------------------------------
module ccl_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ccl_pkg::t_job        i_job,
    input  ccl_pkg::t_queue_stat i_stat,
    output logic                 o_pop,
    output logic                 o_pix_valid,
    output ccl_pkg::t_pix        o_pix
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state                             r_state;
    logic [ccl_pkg::COORD_W-1:0]        r_major;
    logic [ccl_pkg::COORD_W-1:0]        r_minor;
    logic [ccl_pkg::COORD_W-1:0]        r_left;
    logic signed [ccl_pkg::ERR_W-1:0]   r_err;
    logic signed [ccl_pkg::ERR_W-1:0]   r_two_span;
    logic signed [ccl_pkg::ERR_W-1:0]   r_two_delta;
    logic                               r_steep;
    logic [ccl_pkg::GLYPH_W-1:0]        r_glyph;

    logic signed [ccl_pkg::ERR_W-1:0]   n_sum;
    logic signed [ccl_pkg::ERR_W-1:0]   n_err;
    logic [ccl_pkg::COORD_W-1:0]        n_minor;

    assign o_pop = (r_state == ST_IDLE) && !i_stat.empty;

    // remainder stays in [0, 2*span); one correction per step suffices
    always_comb begin
        n_sum = r_err + r_two_delta;
        if (n_sum >= r_two_span) begin
            n_err   = n_sum - r_two_span;
            n_minor = r_minor + 1'b1;
        end else if (n_sum < 0) begin
            n_err   = n_sum + r_two_span;
            n_minor = r_minor - 1'b1;
        end else begin
            n_err   = n_sum;
            n_minor = r_minor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_pix_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    o_pix_valid <= 1'b0;
                    if (!i_stat.empty) begin
                        r_state     <= ST_RUN;
                        r_major     <= i_job.major_start;
                        r_minor     <= i_job.minor_start;
                        r_left      <= i_job.span;
                        r_err       <= ccl_pkg::ERR_W'(i_job.span);
                        r_two_span  <= ccl_pkg::ERR_W'({i_job.span, 1'b0});
                        r_two_delta <= ccl_pkg::ERR_W'(signed'({i_job.delta, 1'b0}));
                        r_steep     <= i_job.steep;
                        r_glyph     <= i_job.glyph;
                    end
                end
                ST_RUN: begin
                    o_pix_valid <= 1'b1;
                    o_pix.x     <= r_steep ? r_minor : r_major;
                    o_pix.y     <= r_steep ? r_major : r_minor;
                    o_pix.glyph <= r_glyph;
                    o_pix.last  <= (r_left == ccl_pkg::COORD_W'(1));
                    r_major     <= r_major + 1'b1;
                    r_minor     <= n_minor;
                    r_err       <= n_err;
                    r_left      <= r_left - 1'b1;
                    if (r_left == ccl_pkg::COORD_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
